### hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the modular exponentiation block: widths, request and
// response payload types, unit result type and the conditional-subtract helper.
// No dependencies.
package mexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    typedef struct packed {
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] modulus;
    } mexp_req_t;

    typedef struct packed {
        logic [WIDTH-1:0] power_mod;
        logic             zero_modulus;
    } mexp_rsp_t;

    // Result of one serial arithmetic unit: done pulse and the value
    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] value;
    } mexp_unit_t;

    // Reduce v (known to be below 2*m) into [0, m)
    function automatic logic [WIDTH-1:0] sub_if_ge(input logic [WIDTH:0] v,
                                                   input logic [WIDTH-1:0] m);
        logic [WIDTH:0] diff;
        diff = v - {1'b0, m};
        if (v >= {1'b0, m}) begin
            return diff[WIDTH-1:0];
        end
        return v[WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
`default_nettype none
// Modular exponentiation: base ** exponent mod modulus, all unsigned WIDTH bits.
// Depends on mexp_pkg, mexp_reduce and mexp_mulmod.
//
// Usage:
//   A request (base, exponent, modulus) is taken on req_valid && req_ready.
//   One response (power_mod, zero_modulus) is offered on rsp_valid and held
//   until rsp_ready. Requests are handled one at a time; req_ready is high
//   only while the sequencer is idle.
//   Sequence: the base is first reduced mod modulus by a bit-serial divider.
//   Then square-and-multiply walks the exponent from the top bit down: every
//   bit costs one modular square and, for a one bit, one modular multiply,
//   both in the bit-serial multiplier, which the square and the multiply share.
//   A zero modulus skips all arithmetic: the response (0, error) is then
//   offered without any divide or multiply.
//   Stall: the response sits in an output register; the next request is
//   accepted while it waits, and that request's result holds in the
//   sequencer until the register frees up.
//   Reset clears the sequencer and the response valid; nothing else is kept
//   between requests.
module modular_exponentiation (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output      logic                req_ready,
    input  wire mexp_pkg::mexp_req_t req_data,
    output      logic                rsp_valid,
    input  wire logic                rsp_ready,
    output      mexp_pkg::mexp_rsp_t rsp_data
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] acc_reg;
    logic             err_reg;
    logic [CNT_W-1:0] bit_cnt_reg;
    logic             rsp_valid_reg;
    mexp_rsp_t        rsp_data_reg;

    logic             req_fire;
    logic             red_start;
    mexp_unit_t       red_res;
    logic             mul_start;
    logic [WIDTH-1:0] mul_x;
    logic [WIDTH-1:0] mul_y;
    mexp_unit_t       mul_res;
    logic             next_is_mult;
    logic             last_bit;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    // start the base reduction right on the accepting edge
    assign red_start = req_fire && (req_data.modulus != '0);
    assign last_bit  = (bit_cnt_reg == '0);

    always_comb
    begin
        mul_start    = 1'b0;
        next_is_mult = 1'b0;
        mul_x        = mul_res.value;
        case (state_reg)
            ST_REDUCE:
            begin
                // first square of the running result, still 1 mod n
                mul_x     = acc_reg;
                mul_start = red_res.done;
            end
            ST_SQUARE:
            begin
                next_is_mult = exp_reg[WIDTH-1];
                mul_start    = mul_res.done && (exp_reg[WIDTH-1] || !last_bit);
            end
            ST_MULT:
            begin
                mul_start = mul_res.done && !last_bit;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
        mul_y = next_is_mult ? base_reg : mul_x;
    end

    mexp_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (red_start),
        .dividend (req_data.base),
        .divisor  (req_data.modulus),
        .result   (red_res)
    );

    mexp_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .x      (mul_x),
        .y      (mul_y),
        .m      (mod_reg),
        .result (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
        end else begin
            // raise the response when a result moves out, drop it once taken
            if (state_reg == ST_DONE && (!rsp_valid_reg || rsp_ready)) begin
                rsp_valid_reg <= 1'b1;
            end else if (rsp_valid_reg && rsp_ready) begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire) begin
                        bit_cnt_reg <= CNT_W'(WIDTH - 1);
                        state_reg   <= (req_data.modulus == '0) ? ST_DONE : ST_REDUCE;
                    end
                end
                ST_REDUCE:
                begin
                    if (red_res.done) begin
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    if (mul_res.done) begin
                        if (exp_reg[WIDTH-1]) begin
                            state_reg <= ST_MULT;
                        end else if (last_bit) begin
                            state_reg <= ST_DONE;
                        end else begin
                            bit_cnt_reg <= bit_cnt_reg - 1'b1;
                        end
                    end
                end
                ST_MULT:
                begin
                    if (mul_res.done) begin
                        if (last_bit) begin
                            state_reg <= ST_DONE;
                        end else begin
                            bit_cnt_reg <= bit_cnt_reg - 1'b1;
                            state_reg   <= ST_SQUARE;
                        end
                    end
                end
                ST_DONE:
                begin
                    // hold the result until the output register is free
                    if (!rsp_valid_reg || rsp_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire) begin
                    exp_reg <= req_data.exponent;
                    mod_reg <= req_data.modulus;
                    err_reg <= (req_data.modulus == '0);
                    // 1 mod n: zero when n is one, and zero on error as well
                    acc_reg <= (req_data.modulus > WIDTH'(1)) ? WIDTH'(1) : '0;
                end
            end
            ST_REDUCE:
            begin
                if (red_res.done) begin
                    base_reg <= red_res.value;
                end
            end
            ST_SQUARE:
            begin
                if (mul_res.done) begin
                    acc_reg <= mul_res.value;
                    if (!exp_reg[WIDTH-1]) begin
                        exp_reg <= {exp_reg[WIDTH-2:0], 1'b0};
                    end
                end
            end
            ST_MULT:
            begin
                if (mul_res.done) begin
                    acc_reg <= mul_res.value;
                    exp_reg <= {exp_reg[WIDTH-2:0], 1'b0};
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready) begin
                    rsp_data_reg.power_mod    <= acc_reg;
                    rsp_data_reg.zero_modulus <= err_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
`default_nettype wire

### hw/rtl/mexp_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial restoring remainder: dividend mod divisor, one bit per cycle.
// Depends on mexp_pkg.
module mexp_reduce (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [mexp_pkg::WIDTH-1:0] dividend,
    input  wire logic [mexp_pkg::WIDTH-1:0] divisor,
    output mexp_pkg::mexp_unit_t         result
);
    import mexp_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] shf_reg, shf_next;
    logic [WIDTH-1:0] div_reg, div_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            rem_next  = '0;
            shf_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            // bring down the next dividend bit, subtract if it fits
            rem_next = sub_if_ge({rem_reg, shf_reg[WIDTH-1]}, div_reg);
            shf_next = {shf_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        div_reg <= div_next;
    end

    assign result.done  = done_reg;
    assign result.value = rem_reg;

endmodule
`default_nettype wire

### hw/rtl/mexp_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial interleaved modular multiplier: x * y mod m by double-and-add,
// one multiplier bit per cycle, most significant first. Depends on mexp_pkg.
module mexp_mulmod (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [mexp_pkg::WIDTH-1:0] x,
    input  wire logic [mexp_pkg::WIDTH-1:0] y,
    input  wire logic [mexp_pkg::WIDTH-1:0] m,
    output mexp_pkg::mexp_unit_t         result
);
    import mexp_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;
    logic [WIDTH-1:0] m_reg, m_next;
    logic [WIDTH-1:0] dbl;
    logic [WIDTH-1:0] dbl_add;

    assign dbl     = sub_if_ge({acc_reg, 1'b0}, m_reg);
    assign dbl_add = sub_if_ge({1'b0, dbl} + {1'b0, x_reg}, m_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            acc_next  = '0;
            x_next    = x;
            y_next    = y;
            m_next    = m;
        end else if (busy_reg) begin
            acc_next = y_reg[WIDTH-1] ? dbl_add : dbl;
            y_next   = {y_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

    assign result.done  = done_reg;
    assign result.value = acc_reg;

endmodule
`default_nettype wire
